// ----- rtl/mhps_pkg.sv -----
// Shared types, constants and helpers for the masked halfword pattern search.
package mhps_pkg;

  localparam int MAX_PATTERN    = 14;
  localparam int INDEX_BITS     = 24;
  localparam int WORD_BITS      = 16;
  localparam int LEN_BITS       = 4;
  localparam int NUM_PAIR_REGS  = 7;
  localparam int NUM_CELLS      = MAX_PATTERN - 1;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int ENTRY_BITS     = 2 * WORD_BITS;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [LEN_BITS-1:0]   len_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LENGTH  = 3'd0,
    REG_PAIRS_0_1       = 3'd1,
    REG_PAIRS_2_3       = 3'd2,
    REG_PAIRS_4_5       = 3'd3,
    REG_PAIRS_6_7       = 3'd4,
    REG_PAIRS_8_9       = 3'd5,
    REG_PAIRS_10_11     = 3'd6,
    REG_PAIRS_12_13     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    word_t value;
    word_t mask;
  } entry_t;

  typedef struct packed {
    logic  use_entry;
    word_t mask;
    word_t value;
  } cell_cfg_t;

  function automatic logic entry_hit(word_t w, word_t mask, word_t value);
    return (w & mask) == value;
  endfunction

endpackage

// ----- rtl/mhps_cfg.sv -----
// Configuration registers and per-cell pattern entry selection.
module mhps_cfg import mhps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output len_t                      len_eff,
  output cell_cfg_t                 head_cfg,
  output cell_cfg_t                 cell_cfg [NUM_CELLS]
);

  len_t                     pattern_length;
  logic [CFG_DATA_BITS-1:0] pairs [NUM_PAIR_REGS];
  entry_t                   entries [MAX_PATTERN];
  len_t                     head_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_BITS'(1);
      for (int i = 0; i < NUM_PAIR_REGS; i++) begin
        pairs[i] <= '0;
      end
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_BITS-1:0];
        REG_PAIRS_0_1:      pairs[0] <= cfg_data;
        REG_PAIRS_2_3:      pairs[1] <= cfg_data;
        REG_PAIRS_4_5:      pairs[2] <= cfg_data;
        REG_PAIRS_6_7:      pairs[3] <= cfg_data;
        REG_PAIRS_8_9:      pairs[4] <= cfg_data;
        REG_PAIRS_10_11:    pairs[5] <= cfg_data;
        REG_PAIRS_12_13:    pairs[6] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (pattern_length > LEN_BITS'(MAX_PATTERN)) begin
      len_eff = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
  end

  for (genvar e = 0; e < MAX_PATTERN; e++) begin : g_entry
    assign entries[e] = entry_t'(pairs[e / 2][(e % 2) * ENTRY_BITS +: ENTRY_BITS]);
  end

  assign head_idx = len_eff - LEN_BITS'(1);

  always_comb begin
    head_cfg.use_entry = 1'b1;
    head_cfg.mask      = entries[head_idx].mask;
    head_cfg.value     = entries[head_idx].value;
  end

  // The word held s+1 steps back is checked against entry len-2-s.
  for (genvar s = 0; s < NUM_CELLS; s++) begin : g_sel
    logic use_it;
    len_t idx;
    assign use_it = len_eff >= LEN_BITS'(s + 2);
    assign idx    = use_it ? len_t'(len_eff - LEN_BITS'(s + 2)) : '0;
    always_comb begin
      cell_cfg[s].use_entry = use_it;
      cell_cfg[s].mask      = entries[idx].mask;
      cell_cfg[s].value     = entries[idx].value;
    end
  end

endmodule

// ----- rtl/mhps_cell.sv -----
// One history cell: holds a past word, passes it on and tests it against its entry.
module mhps_cell import mhps_pkg::*; (
  input  logic      clk,
  input  logic      shift,
  input  word_t     word_in,
  input  cell_cfg_t cfg,
  output word_t     word_out,
  output logic      hit
);

  word_t word;

  always_ff @(posedge clk) begin
    if (shift) begin
      word <= word_in;
    end
  end

  assign word_out = word;
  assign hit      = !cfg.use_entry || entry_hit(word, cfg.mask, cfg.value);

endmodule

// ----- rtl/masked_halfword_pattern_search_top.sv -----
// Top level of the masked halfword pattern search over a word stream.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_stall     data_word, end_of_image
//   out      output     out_valid / out_stall   match_found, match_index
//   cfg      input      cfg_write_en            cfg_index, cfg_data
//
// One word is taken every cycle while the input is not stalled; the full window compare
// across the cell row and the head word finishes in the cycle of the transfer.
// A result is written into the output register in the cycle after its input transfer.
// Input stalls only while a result sits in the output register and is stalled.
// Synchronous reset clears the counter, the match flag, the output valid flag and
// the configuration registers; history words and result fields need no reset.
module masked_halfword_pattern_search_top import mhps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  word_t                     data_word,
  input  logic                      end_of_image,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      match_found,
  output index_t                    match_index,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  len_t           len_eff;
  cell_cfg_t      head_cfg;
  cell_cfg_t      cell_cfg [NUM_CELLS];
  word_t          chain_in [NUM_CELLS];
  word_t          chain_out [NUM_CELLS];
  logic [NUM_CELLS-1:0] cell_hit;

  index_t words_seen;
  index_t words_seen_next;
  logic   already_reported;
  logic   accept;
  logic   test_ok;
  logic   window_hit;
  logic   emit;
  index_t start_index;

  mhps_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .len_eff      (len_eff),
    .head_cfg     (head_cfg),
    .cell_cfg     (cell_cfg)
  );

  for (genvar s = 0; s < NUM_CELLS; s++) begin : g_cell
    if (s == 0) begin : g_first
      assign chain_in[s] = data_word;
    end else begin : g_rest
      assign chain_in[s] = chain_out[s-1];
    end
    mhps_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .word_in  (chain_in[s]),
      .cfg      (cell_cfg[s]),
      .word_out (chain_out[s]),
      .hit      (cell_hit[s])
    );
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign start_index = words_seen - index_t'(len_eff - LEN_BITS'(1));
  assign test_ok     = !already_reported && (words_seen != '1) &&
                       (words_seen >= index_t'(len_eff - LEN_BITS'(1)));
  assign window_hit  = test_ok && entry_hit(data_word, head_cfg.mask, head_cfg.value) &&
                       (&cell_hit);
  assign emit        = window_hit || (end_of_image && !already_reported);

  assign words_seen_next = (words_seen == '1) ? words_seen : words_seen + INDEX_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      words_seen       <= '0;
      already_reported <= 1'b0;
    end else if (accept) begin
      if (end_of_image) begin
        words_seen       <= '0;
        already_reported <= 1'b0;
      end else begin
        words_seen       <= words_seen_next;
        already_reported <= already_reported || window_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      match_found <= window_hit;
      match_index <= window_hit ? start_index : '0;
    end
  end

endmodule

// ----- rtl/mhps_checker.sv -----
// Port-level checks for the masked halfword pattern search, bound to the top level.
module mhps_checker import mhps_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_stall,
  input logic   out_valid,
  input logic   out_stall,
  input logic   match_found,
  input index_t match_index
);

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("Input was not stalled while a result was held.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(match_found) && $stable(match_index))
    else $error("Stalled result changed or was dropped.");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_found |-> match_index == '0)
    else $error("Not-found result carries a nonzero index.");

  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("Result appeared without an input transfer.");

endmodule

bind masked_halfword_pattern_search_top mhps_checker u_mhps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .match_found (match_found),
  .match_index (match_index)
);
